/* rtl/fat12te_pkg.sv */
// fat12te_pkg: shared constants for the fat12 table engine
// operation and status codes, table marks and parameter defaults
// no dependencies
package fat12te_pkg;

    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int MAX_CHAIN_DEF   = 64;

    localparam int ENTRY_W   = 12;
    localparam int OPCODE_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int BYTES_W   = 16;
    localparam int NEED_W    = 8;
    localparam int CLUSTER_SHIFT = 9;

    localparam logic [ENTRY_W-1:0] CLUSTER_COUNT_RESET = 12'd2847;
    localparam logic [ENTRY_W-1:0] END_MARK            = 12'hfff;
    localparam logic [ENTRY_W-1:0] MEDIA_ENTRY0        = 12'hff0;
    localparam logic [BYTES_W:0]   CLUSTER_ROUND       = 17'd511;

    localparam logic [OPCODE_W-1:0] OP_READ     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ALLOCATE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_FORMAT   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

endpackage

/* rtl/fat12te_ram.sv */
// fat12te_ram: simple dual-port synchronous ram, one write and one read port
// read data registered, valid in the cycle after the address; no dependencies
module fat12te_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 12
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/fat12_table_engine.sv */
// fat12_table_engine: fat12 allocation table held as one 12-bit word per entry
// depends on fat12te_pkg and fat12te_ram
//
// a write lands on acceptance, a read passes the table ram and S_READ, format sweeps
// the table, allocate scans entries (S_SCAN_TEST, S_SCAN_CHK), then links each chain
// cluster (S_LINK_RD, S_LINK_WR); one word at a time, pace set by the single read
// port of the table ram. reset: a sweep rewrites the table (busy high), no result.
// results carry a one-cycle strobe and cannot be held off by the receiver.
module fat12_table_engine #(
    parameter int MAX_ENTRIES = fat12te_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_CHAIN   = fat12te_pkg::MAX_CHAIN_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [fat12te_pkg::OPCODE_W-1:0]      opcode,
    input  logic [fat12te_pkg::ENTRY_W-1:0]       entry_index,
    input  logic [fat12te_pkg::ENTRY_W-1:0]       entry_value,
    input  logic [fat12te_pkg::BYTES_W-1:0]       req_bytes,
    input  logic                                  cfg_we,
    input  logic [fat12te_pkg::ENTRY_W-1:0]       cfg_wdata,
    output logic                                  result_valid,
    output logic [fat12te_pkg::STATUS_W-1:0]      status,
    output logic [fat12te_pkg::ENTRY_W-1:0]       entry_out,
    output logic [fat12te_pkg::ENTRY_W-1:0]       cluster_out,
    output logic                                  last
);
    import fat12te_pkg::*;

    // table address, scan counter (may reach MAX_ENTRIES), chain address and count
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IW = AW + 1;
    localparam int CW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam int FW = $clog2(MAX_CHAIN + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN_TEST,
        S_SCAN_CHK,
        S_LINK_RD,
        S_LINK_WR
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         clr_reg;
    logic                  fmt_reg;        // report a result at the end of the sweep
    logic                  rd_ok_reg;      // read index inside the table
    logic [ENTRY_W-1:0]    count_reg;
    logic [IW-1:0]         scan_reg;
    logic [IW-1:0]         end_reg;
    logic [NEED_W-1:0]     need_reg;
    logic [FW-1:0]         found_reg;
    logic [FW-1:0]         link_reg;
    logic [ENTRY_W-1:0]    cur_reg;
    logic                  valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ENTRY_W-1:0]    entry_reg;
    logic [ENTRY_W-1:0]    cluster_reg;
    logic                  last_reg;

    // table ram ports
    logic                  tbl_we;
    logic [AW-1:0]         tbl_waddr;
    logic [ENTRY_W-1:0]    tbl_wdata;
    logic [AW-1:0]         tbl_raddr;
    logic [ENTRY_W-1:0]    tbl_q;

    // chain buffer ports
    logic                  chn_we;
    logic [CW-1:0]         chn_waddr;
    logic [CW-1:0]         chn_raddr;
    logic [ENTRY_W-1:0]    chn_q;

    logic                  accept;
    logic                  idx_ok;
    logic [FW-1:0]         link_inc;
    logic                  link_last;
    logic [BYTES_W:0]      bytes_round;
    logic [NEED_W-1:0]     need_c;
    logic [ENTRY_W:0]      end_full;
    logic [ENTRY_W:0]      end_clamp;

    assign accept    = start && (state_reg == S_IDLE);
    assign idx_ok    = ({1'b0, entry_index} < (ENTRY_W+1)'(MAX_ENTRIES));
    assign link_inc  = link_reg + FW'(1);
    assign link_last = (link_inc == found_reg);

    // clusters needed, rounded up
    assign bytes_round = {1'b0, req_bytes} + CLUSTER_ROUND;
    assign need_c      = NEED_W'(bytes_round >> CLUSTER_SHIFT);

    // scan bound, never past the last table entry
    assign end_full  = {1'b0, count_reg} + (ENTRY_W+1)'(2);
    assign end_clamp = (end_full > (ENTRY_W+1)'(MAX_ENTRIES)) ?
                       (ENTRY_W+1)'(MAX_ENTRIES) : end_full;

    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = clr_reg;
        tbl_wdata = '0;
        tbl_raddr = scan_reg[AW-1:0];
        chn_we    = 1'b0;
        chn_waddr = found_reg[CW-1:0];
        chn_raddr = link_inc[CW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                if (clr_reg == AW'(0))
                begin
                    tbl_wdata = MEDIA_ENTRY0;
                end
                else if (clr_reg == AW'(1))
                begin
                    tbl_wdata = END_MARK;
                end
            end
            S_IDLE:
            begin
                tbl_raddr = entry_index[AW-1:0];
                if (accept && (opcode == OP_WRITE) && idx_ok)
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = entry_index[AW-1:0];
                    tbl_wdata = entry_value;
                end
            end
            S_SCAN_CHK:
            begin
                chn_we = (tbl_q == '0);
            end
            S_LINK_WR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = cur_reg[AW-1:0];
                tbl_wdata = link_last ? END_MARK : chn_q;
            end
            default:
            begin
            end
        endcase
    end

    fat12te_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_q)
    );

    fat12te_ram #(
        .DEPTH (MAX_CHAIN),
        .WIDTH (ENTRY_W)
    ) u_chain (
        .clk   (clk),
        .we    (chn_we),
        .waddr (chn_waddr),
        .wdata (ENTRY_W'(scan_reg)),
        .raddr (chn_raddr),
        .rdata (chn_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            fmt_reg     <= 1'b0;
            count_reg   <= CLUSTER_COUNT_RESET;
            valid_reg   <= 1'b0;
            rd_ok_reg   <= 1'b0;
            scan_reg    <= '0;
            end_reg     <= '0;
            need_reg    <= '0;
            found_reg   <= '0;
            link_reg    <= '0;
            cur_reg     <= '0;
            status_reg  <= ST_OK;
            entry_reg   <= '0;
            cluster_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAX_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                        if (fmt_reg)
                        begin
                            valid_reg   <= 1'b1;
                            status_reg  <= ST_OK;
                            entry_reg   <= '0;
                            cluster_reg <= '0;
                            last_reg    <= 1'b1;
                        end
                        fmt_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg  <= ST_OK;
                        entry_reg   <= '0;
                        cluster_reg <= '0;
                        last_reg    <= 1'b1;
                        rd_ok_reg   <= idx_ok;
                        case (opcode)
                            OP_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            OP_WRITE:
                            begin
                                valid_reg <= 1'b1;
                            end
                            OP_FORMAT:
                            begin
                                clr_reg   <= '0;
                                fmt_reg   <= 1'b1;
                                state_reg <= S_CLEAR;
                            end
                            default:
                            begin
                                // allocate chain
                                if (req_bytes == '0)
                                begin
                                    valid_reg  <= 1'b1;
                                    status_reg <= ST_EMPTY;
                                end
                                else if (need_c > NEED_W'(MAX_CHAIN))
                                begin
                                    valid_reg  <= 1'b1;
                                    status_reg <= ST_NOSPACE;
                                end
                                else
                                begin
                                    need_reg  <= need_c;
                                    found_reg <= '0;
                                    scan_reg  <= IW'(2);
                                    end_reg   <= IW'(end_clamp);
                                    state_reg <= S_SCAN_TEST;
                                end
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    valid_reg <= 1'b1;
                    entry_reg <= rd_ok_reg ? tbl_q : '0;
                    state_reg <= S_IDLE;
                end
                S_SCAN_TEST:
                begin
                    if (NEED_W'(found_reg) == need_reg)
                    begin
                        link_reg  <= '0;
                        state_reg <= S_LINK_RD;
                    end
                    else if (scan_reg >= end_reg)
                    begin
                        valid_reg  <= 1'b1;
                        status_reg <= ST_NOSPACE;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK:
                begin
                    if (tbl_q == '0)
                    begin
                        found_reg <= found_reg + FW'(1);
                        if (found_reg == '0)
                        begin
                            cur_reg <= ENTRY_W'(scan_reg);
                        end
                    end
                    scan_reg  <= scan_reg + IW'(1);
                    state_reg <= S_SCAN_TEST;
                end
                S_LINK_RD:
                begin
                    state_reg <= S_LINK_WR;
                end
                S_LINK_WR:
                begin
                    valid_reg   <= 1'b1;
                    status_reg  <= ST_OK;
                    entry_reg   <= '0;
                    cluster_reg <= cur_reg;
                    last_reg    <= link_last;
                    cur_reg     <= chn_q;
                    link_reg    <= link_inc;
                    state_reg   <= link_last ? S_IDLE : S_LINK_RD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign entry_out    = entry_reg;
    assign cluster_out  = cluster_reg;
    assign last         = last_reg;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for fat12_table_engine
// keeps its own copy of the packed fat12 table and checks every result word
// depends on fat12te_pkg and the rtl of the engine
module tb_top;
    import fat12te_pkg::*;

    localparam int N_ENTRIES   = MAX_ENTRIES_DEF;
    localparam int N_CHAIN     = MAX_CHAIN_DEF;
    localparam int TABLE_BYTES = (N_ENTRIES * 3 + 1) / 2;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [ENTRY_W-1:0]  idx;
        logic [ENTRY_W-1:0]  val;
        logic [BYTES_W-1:0]  nbytes;
    } fat_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [ENTRY_W-1:0]  ent;
        logic [ENTRY_W-1:0]  clu;
        logic                lst;
    } fat_word_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OPCODE_W-1:0] opcode;
    logic [ENTRY_W-1:0]  entry_index;
    logic [ENTRY_W-1:0]  entry_value;
    logic [BYTES_W-1:0]  req_bytes;
    logic                cfg_we;
    logic [ENTRY_W-1:0]  cfg_wdata;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry_out;
    logic [ENTRY_W-1:0]  cluster_out;
    logic                last;

    fat12_table_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .entry_index   (entry_index),
        .entry_value   (entry_value),
        .req_bytes     (req_bytes),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_valid  (result_valid),
        .status        (status),
        .entry_out     (entry_out),
        .cluster_out   (cluster_out),
        .last          (last)
    );

    // shadow of the table and the cluster count register
    logic [7:0]         shadow_fat [TABLE_BYTES];
    logic [ENTRY_W-1:0] shadow_count;

    fat_cmd_t  cmd_queue [$];     // words waiting to be driven
    fat_word_t expected_words [$];

    int  mismatches = 0;
    bit  quiet_mode = 0;          // stretch with no idling on the driver

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic logic [ENTRY_W-1:0] shadow_get(int n);
        int off;
        if (n >= N_ENTRIES) return '0;
        off = (n * 3) / 2;
        if (off + 1 >= TABLE_BYTES) return '0;
        if (n & 1)
            return {shadow_fat[off+1], shadow_fat[off][7:4]};
        return {shadow_fat[off+1][3:0], shadow_fat[off]};
    endfunction

    // odd entries keep the low nibble of their first byte, even ones the
    // upper nibble of their second byte
    function automatic void shadow_put(int n, logic [ENTRY_W-1:0] v);
        int off;
        if (n >= N_ENTRIES) return;
        off = (n * 3) / 2;
        if (off + 1 >= TABLE_BYTES) return;
        if (n & 1)
        begin
            shadow_fat[off]   = {v[3:0], shadow_fat[off][3:0]};
            shadow_fat[off+1] = v[11:4];
        end
        else
        begin
            shadow_fat[off]   = v[7:0];
            shadow_fat[off+1] = {shadow_fat[off+1][7:4], v[11:8]};
        end
    endfunction

    function automatic void shadow_format();
        foreach (shadow_fat[i]) shadow_fat[i] = 8'h00;
        shadow_fat[0] = 8'hf0;
        shadow_fat[1] = 8'hff;
        shadow_fat[2] = 8'hff;
    endfunction

    function automatic void push_word(logic [STATUS_W-1:0] st, logic [ENTRY_W-1:0] ent,
                                      logic [ENTRY_W-1:0] clu, logic lst);
        fat_word_t w;
        w.st = st; w.ent = ent; w.clu = clu; w.lst = lst;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // works out the result words of one accepted command
    function automatic void predict_table_op(fat_cmd_t c);
        int need, found, scan_end;
        int chain [$];
        case (c.op)
            OP_READ:   push_word(ST_OK, shadow_get(c.idx), '0, 1'b1);
            OP_WRITE:
            begin
                shadow_put(c.idx, c.val);
                push_word(ST_OK, '0, '0, 1'b1);
            end
            OP_FORMAT:
            begin
                shadow_format();
                push_word(ST_OK, '0, '0, 1'b1);
            end
            default:
            begin
                if (c.nbytes == 0)
                begin
                    push_word(ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                need = (int'(c.nbytes) + 511) / 512;
                if (need > N_CHAIN)
                begin
                    push_word(ST_NOSPACE, '0, '0, 1'b1);
                    return;
                end
                scan_end = int'(shadow_count) + 2;
                if (scan_end > N_ENTRIES) scan_end = N_ENTRIES;
                found = 0;
                for (int i = 2; i < scan_end && found < need; i++)
                    if (shadow_get(i) == 0)
                    begin
                        chain.insert(chain.size(), i);
                        found++;
                    end
                if (found < need)
                begin
                    push_word(ST_NOSPACE, '0, '0, 1'b1);
                    return;
                end
                for (int i = 0; i < found; i++)
                begin
                    shadow_put(chain[i], (i + 1 < found) ? ENTRY_W'(chain[i+1]) : END_MARK);
                    push_word(ST_OK, '0, ENTRY_W'(chain[i]), (i + 1 == found));
                end
            end
        endcase
    endfunction

    // accepted command: predict its result words
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            predict_table_op(cmd_queue.pop_front());
        end
    end

    // driver: presents the head of the queue, idles at random
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            opcode      <= '0;
            entry_index <= '0;
            entry_value <= '0;
            req_bytes   <= '0;
        end
        else if (cmd_queue.size() != 0 && (quiet_mode || $urandom_range(99) >= 20))
        begin
            start       <= 1'b1;
            opcode      <= cmd_queue[0].op;
            entry_index <= cmd_queue[0].idx;
            entry_value <= cmd_queue[0].val;
            req_bytes   <= cmd_queue[0].nbytes;
        end
        else
        begin
            start       <= 1'b0;
            opcode      <= OPCODE_W'($urandom);
            entry_index <= ENTRY_W'($urandom);
            entry_value <= ENTRY_W'($urandom);
            req_bytes   <= BYTES_W'($urandom);
        end
    end

    // monitor: every strobed word is checked against the oldest expectation
    always @(posedge clk)
    begin
        fat_word_t exp_w;
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word st=%0d ent=%h clu=%h last=%b",
                             status, entry_out, cluster_out, last);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (status !== exp_w.st || entry_out !== exp_w.ent ||
                    cluster_out !== exp_w.clu || last !== exp_w.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp st=%0d ent=%h clu=%h last=%b",
                                  " got st=%0d ent=%h clu=%h last=%b"},
                                 exp_w.st, exp_w.ent, exp_w.clu, exp_w.lst,
                                 status, entry_out, cluster_out, last);
                end
            end
        end
    end

    function automatic void queue_cmd(logic [OPCODE_W-1:0] op, int idx, int val, int nb);
        fat_cmd_t c;
        c.op     = op;
        c.idx    = ENTRY_W'(idx);
        c.val    = ENTRY_W'(val);
        c.nbytes = BYTES_W'(nb);
        cmd_queue.insert(cmd_queue.size(), c);
    endfunction

    // random chain-heavy traffic; mostly small requests, low indices
    function automatic void queue_random(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                queue_cmd(OP_ALLOCATE, $urandom, $urandom,
                          ($urandom_range(9) == 0) ? $urandom : $urandom_range(4096));
            else if (r < 60)
                queue_cmd(OP_READ, ($urandom_range(3) == 0) ? $urandom : $urandom_range(80),
                          $urandom, $urandom);
            else if (r < 90)
                queue_cmd(OP_WRITE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(80),
                          ($urandom_range(1)) ? 0 : $urandom, $urandom);
            else if (r < 93)
                queue_cmd(OP_FORMAT, $urandom, $urandom, $urandom);
            else
                queue_cmd(OP_READ, $urandom, $urandom, $urandom);
        end
    endfunction

    task automatic drain_and_settle();
        while (cmd_queue.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
        // let the engine settle before the count register changes
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(logic [ENTRY_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_count = v;
    endtask

    initial
    begin
        rst_n = 0; cfg_we = 0; cfg_wdata = '0;
        shadow_format();
        shadow_count = CLUSTER_COUNT_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // directed: media entries, extremes, every operation
        queue_cmd(OP_READ, 0, 0, 0);
        queue_cmd(OP_READ, 1, 0, 0);
        queue_cmd(OP_READ, 4095, 0, 0);
        queue_cmd(OP_WRITE, 4095, 12'hfff, 0);
        queue_cmd(OP_READ, 4095, 0, 0);
        queue_cmd(OP_WRITE, 4094, 12'hfff, 0);
        queue_cmd(OP_WRITE, 4094, 12'h000, 0);
        queue_cmd(OP_READ, 4095, 0, 0);
        queue_cmd(OP_WRITE, 5, 12'hfff, 0);
        queue_cmd(OP_WRITE, 4, 12'h123, 0);
        queue_cmd(OP_READ, 5, 0, 0);
        queue_cmd(OP_WRITE, 5, 12'h000, 0);
        queue_cmd(OP_READ, 4, 0, 0);
        queue_cmd(OP_ALLOCATE, 0, 0, 0);
        queue_cmd(OP_ALLOCATE, 0, 0, 1);
        queue_cmd(OP_ALLOCATE, 0, 0, 513);
        queue_cmd(OP_ALLOCATE, 0, 0, 32768);
        queue_cmd(OP_ALLOCATE, 0, 0, 32769);
        queue_cmd(OP_ALLOCATE, 0, 0, 16'hffff);
        queue_cmd(OP_READ, 2, 0, 0);
        queue_cmd(OP_FORMAT, 0, 0, 0);
        queue_cmd(OP_READ, 2, 0, 0);
        drain_and_settle();

        // tiny data area: too little space, then the full scan bound
        write_count(12'd0);
        queue_cmd(OP_ALLOCATE, 0, 0, 1);
        drain_and_settle();
        write_count(12'd1);
        queue_cmd(OP_ALLOCATE, 0, 0, 512);
        queue_cmd(OP_ALLOCATE, 0, 0, 1);
        queue_random(60);
        drain_and_settle();

        write_count(12'd4095);
        quiet_mode = 1;
        queue_random(80);
        drain_and_settle();
        quiet_mode = 0;

        write_count(12'd40);
        queue_random(130);
        drain_and_settle();

        write_count(12'd4084);
        queue_random(90);
        drain_and_settle();

        if (mismatches == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
